### design/pcwd_pkg.sv
// Shared constants, opcodes and types of the pausable clock with deadlines.
`default_nettype none

package pcwd_pkg;

    localparam int MAX_DEADLINES    = 8;
    localparam int MS_PER_TICK      = 10;
    localparam int TICKS_PER_SECOND = 100;

    localparam int SLOT_W = (MAX_DEADLINES > 1) ? $clog2(MAX_DEADLINES) : 1;
    localparam int MS_W   = $clog2(MS_PER_TICK + 1);
    localparam int PROD_W = 32 + MS_W;
    localparam int END_W  = PROD_W + 1;

    // floor(2^32 / TICKS_PER_SECOND); quotient estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / TICKS_PER_SECOND);
    localparam logic [31:0] TPS32 = 32'(TICKS_PER_SECOND);
    localparam logic [PROD_W-1:0] MS_MUL = PROD_W'(MS_PER_TICK);

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_ADD     = 3'd4;
    localparam logic [2:0] OP_REMOVE  = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ticks;
        logic [31:0] from_ticks;
        logic [31:0] deadline_ms;
        logic [2:0]  slot_index;
    } t_event_in;

    typedef struct packed {
        logic [31:0] elapsed_ms;
        logic [31:0] time_to_first_ms;
        logic        any_reached;
        logic        has_deadline;
        logic [2:0]  assigned_slot;
        logic        table_full;
        logic        second_changed;
    } t_event_out;

    // broadcast from the control block to every slot cell
    typedef struct packed {
        logic              clr;
        logic [31:0]       from_ticks;
        logic [31:0]       deadline_ms;
        logic [31:0]       stopped;
        logic [PROD_W-1:0] cur_ms;
    } t_cell_ctl;

    // running reduction handed from cell to cell
    typedef struct packed {
        logic             tok;
        logic             any;
        logic             reached;
        logic [END_W-1:0] min_left;
    } t_scan;

endpackage

`default_nettype wire

### design/pcwd_cell.sv
// One deadline slot: holds the slot, works out its time left, folds it into the scan.
`default_nettype none

module pcwd_cell import pcwd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_add_sel,
    input  logic      i_rm_sel,
    input  t_scan     i_scan,
    output t_scan     o_scan,
    output logic      o_valid
);

    logic              r_valid;
    logic [31:0]       r_start;
    logic [31:0]       r_len;
    logic [31:0]       r_sum;
    logic [END_W-1:0]  r_end;
    logic [END_W-1:0]  r_left;
    logic [PROD_W-1:0] end_prod;
    logic [END_W-1:0]  cur_ext;

    logic             r_tok;
    logic             r_any;
    logic             r_reached;
    logic [END_W-1:0] r_min;
    logic             n_any;
    logic             n_reached;
    logic [END_W-1:0] n_min;

    assign end_prod = PROD_W'(r_sum) * MS_MUL;
    assign cur_ext  = END_W'(i_ctl.cur_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_scan.tok;
            if (i_ctl.clr) begin
                r_valid <= 1'b0;
            end else if (i_add_sel) begin
                r_valid <= 1'b1;
            end else if (i_rm_sel) begin
                r_valid <= 1'b0;
            end
        end
    end

    // free-running: shifted start, end time, then time left
    always_ff @(posedge i_clk) begin
        if (i_add_sel) begin
            r_start <= i_ctl.from_ticks;
            r_len   <= i_ctl.deadline_ms;
        end
        r_sum     <= r_start + i_ctl.stopped;
        r_end     <= END_W'(end_prod) + END_W'(r_len);
        r_left    <= (r_end > cur_ext) ? (r_end - cur_ext) : '0;
        r_any     <= n_any;
        r_reached <= n_reached;
        r_min     <= n_min;
    end

    always_comb begin
        n_any     = i_scan.any;
        n_reached = i_scan.reached;
        n_min     = i_scan.min_left;
        if (i_scan.tok && r_valid) begin
            if (r_left == '0) begin
                n_reached = 1'b1;
            end
            if (!i_scan.any || (r_left < i_scan.min_left)) begin
                n_min = r_left;
            end
            n_any = 1'b1;
        end
    end

    always_comb begin
        o_scan.tok      = r_tok;
        o_scan.any      = r_any;
        o_scan.reached  = r_reached;
        o_scan.min_left = r_min;
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

### design/pausable_clock_with_deadlines.sv
// Top level: event control, clock state and the chain of deadline slot cells.
//
// One event is taken when start is high and busy is low; its result appears on
// o_result with o_strobe high for one cycle, and busy drops in that same cycle so
// the next request can follow at once. The result first waits on the opcode
// update and multiply steps, then on a scan token that walks the chain
// of slot cells one cell per cycle, gathering the smallest time left. Results
// cannot be held off: o_result is valid only while o_strobe is high.
`default_nettype none

module pausable_clock_with_deadlines import pcwd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_event_in  i_event,
    output logic       busy,
    output logic       o_strobe,
    output t_event_out o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_CALC_A,
        S_CALC_B,
        S_CALC_C,
        S_SETTLE,
        S_LAUNCH,
        S_SCAN
    } t_state;

    t_state     r_state;
    t_event_in  r_in;
    t_event_out r_result;
    logic       r_strobe;

    logic [31:0] r_turn_start;
    logic        r_is_stopped;
    logic [31:0] r_stop_began;
    logic [31:0] r_paused;
    logic [31:0] r_last_sec;
    logic [2:0]  r_assigned;
    logic        r_full;
    logic        r_sec_flag;

    logic [64:0]       r_quot_prod;
    logic [31:0]       r_q0;
    logic [31:0]       r_qt;
    logic [31:0]       r_stopped;
    logic [31:0]       r_diff;
    logic              r_under;
    logic [PROD_W-1:0] r_cur_ms;
    logic [PROD_W-1:0] r_el_prod;
    logic [31:0]       r_elapsed;

    logic [31:0] n_stopped;
    logic [31:0] n_since;
    logic [31:0] n_rem;
    logic [31:0] n_secs;

    logic [MAX_DEADLINES-1:0] valid_vec;
    logic [MAX_DEADLINES-1:0] add_sel;
    logic [MAX_DEADLINES-1:0] rm_sel;
    logic [SLOT_W-1:0]        free_idx;
    logic                     free_found;
    t_cell_ctl                cell_ctl;
    t_scan                    chain [0:MAX_DEADLINES];
    t_scan                    last_scan;

    // lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = MAX_DEADLINES - 1; i >= 0; i--) begin
            if (!valid_vec[i]) begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_since   = r_in.now_ticks - r_turn_start;
        n_stopped = r_paused + (r_is_stopped ? (r_in.now_ticks - r_stop_began) : 32'd0);
        n_rem     = r_in.now_ticks - r_qt;
        n_secs    = r_q0 + ((n_rem >= TPS32) ? 32'd1 : 32'd0);
    end

    always_comb begin
        cell_ctl.clr         = (r_state == S_OP) && (r_in.opcode == OP_CLEAR);
        cell_ctl.from_ticks  = r_in.from_ticks;
        cell_ctl.deadline_ms = r_in.deadline_ms;
        cell_ctl.stopped     = r_stopped;
        cell_ctl.cur_ms      = r_cur_ms;
    end

    assign chain[0] = '{tok: (r_state == S_LAUNCH), any: 1'b0, reached: 1'b0, min_left: '0};

    genvar g;
    generate
        for (g = 0; g < MAX_DEADLINES; g++) begin : g_cell
            assign add_sel[g] = (r_state == S_OP) && (r_in.opcode == OP_ADD) &&
                                free_found && (free_idx == SLOT_W'(g));
            assign rm_sel[g]  = (r_state == S_OP) && (r_in.opcode == OP_REMOVE) &&
                                (32'(r_in.slot_index) == 32'(g));
            pcwd_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (cell_ctl),
                .i_add_sel (add_sel[g]),
                .i_rm_sel  (rm_sel[g]),
                .i_scan    (chain[g]),
                .o_scan    (chain[g+1]),
                .o_valid   (valid_vec[g])
            );
        end
    endgenerate

    assign last_scan = chain[MAX_DEADLINES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_turn_start <= '0;
            r_is_stopped <= 1'b0;
            r_stop_began <= '0;
            r_paused     <= '0;
            r_last_sec   <= '0;
            r_assigned   <= '0;
            r_full       <= 1'b0;
            r_sec_flag   <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_SCAN) && last_scan.tok;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in    <= i_event;
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    r_sec_flag <= (r_in.opcode == OP_RESTART);
                    r_assigned <= '0;
                    r_full     <= 1'b0;
                    case (r_in.opcode)
                        OP_RESTART: begin
                            r_turn_start <= r_in.from_ticks;
                            if (r_is_stopped) begin
                                r_stop_began <= r_in.from_ticks;
                            end
                            r_paused <= '0;
                        end
                        OP_STOP: begin
                            if (!r_is_stopped) begin
                                r_stop_began <= r_in.now_ticks;
                                r_is_stopped <= 1'b1;
                            end
                        end
                        OP_RESUME: begin
                            if (r_is_stopped) begin
                                r_paused     <= r_paused + (r_in.now_ticks - r_stop_began);
                                r_is_stopped <= 1'b0;
                            end
                        end
                        OP_ADD: begin
                            r_assigned <= free_found ? 3'(free_idx) : 3'd0;
                            r_full     <= !free_found;
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_CALC_A;
                end
                S_CALC_A: r_state <= S_CALC_B;
                S_CALC_B: r_state <= S_CALC_C;
                S_CALC_C: begin
                    if (n_secs > r_last_sec) begin
                        r_last_sec <= n_secs;
                        r_sec_flag <= 1'b1;
                    end
                    r_state <= S_SETTLE;
                end
                S_SETTLE: r_state <= S_LAUNCH;
                S_LAUNCH: r_state <= S_SCAN;
                S_SCAN: begin
                    if (last_scan.tok) begin
                        r_result.elapsed_ms       <= r_elapsed;
                        r_result.time_to_first_ms <= (|last_scan.min_left[END_W-1:32]) ?
                                                     32'hFFFF_FFFF :
                                                     last_scan.min_left[31:0];
                        r_result.any_reached      <= last_scan.reached;
                        r_result.has_deadline     <= last_scan.any;
                        r_result.assigned_slot    <= r_assigned;
                        r_result.table_full       <= r_full;
                        r_result.second_changed   <= r_sec_flag;
                        r_state                   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // arithmetic pipeline; each step reads only registers written in earlier steps
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_OP: begin
                r_quot_prod <= 65'(r_in.now_ticks) * 65'(RECIP);
            end
            S_CALC_A: begin
                r_q0      <= r_quot_prod[63:32];
                r_stopped <= n_stopped;
                r_under   <= n_stopped > n_since;
                r_diff    <= n_since - n_stopped;
                r_cur_ms  <= PROD_W'(r_in.now_ticks) * MS_MUL;
            end
            S_CALC_B: begin
                r_qt      <= r_q0 * TPS32;
                r_el_prod <= PROD_W'(r_diff) * MS_MUL;
            end
            S_CALC_C: begin
                if (r_under) begin
                    r_elapsed <= '0;
                end else if (|r_el_prod[PROD_W-1:32]) begin
                    r_elapsed <= 32'hFFFF_FFFF;
                end else begin
                    r_elapsed <= r_el_prod[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_SCAN))
        else $error("result strobe without a finished scan");

    a_has_deadline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.has_deadline == (|valid_vec)))
        else $error("has_deadline disagrees with slot state");

    a_full_means_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.table_full) |-> (&valid_vec))
        else $error("table_full with a free slot");

    a_reached_zero_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.any_reached) |-> (o_result.time_to_first_ms == 32'd0))
        else $error("deadline reached but time left is not zero");

endmodule

`default_nettype wire

### verif/pausable_clock_with_deadlines_tb.sv
// Self-checking testbench for the pausable clock with deadlines: directed and random requests.

module pausable_clock_with_deadlines_tb;
    import pcwd_pkg::*;

    localparam int          RANDOM_REQUESTS = 1250;
    localparam int          SETTLE_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT     = 400_000;
    // top opcode has no name in the package; it acts as a plain tick
    localparam logic [2:0]  OP_SPARE        = 3'd7;

    // holds its own copy of the clock and slot table, predicts each result
    class clock_deadline_scoreboard;
        t_event_out  expected_reports[$];
        int unsigned mismatches;
        logic [31:0] turn_start;
        logic [31:0] stop_began;
        logic [31:0] paused_total;
        logic [31:0] last_second;
        logic        stopped;
        logic        slot_valid[MAX_DEADLINES];
        logic [31:0] slot_start[MAX_DEADLINES];
        logic [31:0] slot_length[MAX_DEADLINES];

        function new();
            mismatches   = 0;
            turn_start   = '0;
            stop_began   = '0;
            paused_total = '0;
            last_second  = '0;
            stopped      = 1'b0;
            for (int i = 0; i < MAX_DEADLINES; i++) begin
                slot_valid[i]  = 1'b0;
                slot_start[i]  = '0;
                slot_length[i] = '0;
            end
        endfunction

        function logic [31:0] clamp_ms(logic [63:0] v);
            return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function void note_request(t_event_in ev);
            t_event_out  r;
            logic [31:0] now;
            logic [31:0] secs;
            logic [31:0] since;
            logic [31:0] held;
            logic [31:0] run;
            logic [31:0] shifted;
            logic [63:0] end_ms;
            logic [63:0] cur_ms;
            logic [63:0] left;
            logic [63:0] min_left;
            logic        any;
            int          i;

            r        = '0;
            any      = 1'b0;
            min_left = '0;
            now      = ev.now_ticks;

            case (ev.opcode)
                OP_RESTART: begin
                    turn_start = ev.from_ticks;
                    if (stopped)
                        stop_began = ev.from_ticks;
                    paused_total     = '0;
                    r.second_changed = 1'b1;
                end
                OP_STOP: begin
                    if (!stopped) begin
                        stop_began = now;
                        stopped    = 1'b1;
                    end
                end
                OP_RESUME: begin
                    if (stopped) begin
                        paused_total = paused_total + (now - stop_began);
                        stopped      = 1'b0;
                    end
                end
                OP_ADD: begin
                    r.table_full = 1'b1;
                    for (i = 0; i < MAX_DEADLINES; i++) begin
                        if (!slot_valid[i] && r.table_full) begin
                            slot_valid[i]   = 1'b1;
                            slot_start[i]   = ev.from_ticks;
                            slot_length[i]  = ev.deadline_ms;
                            r.assigned_slot = 3'(i);
                            r.table_full    = 1'b0;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (ev.slot_index < MAX_DEADLINES)
                        slot_valid[ev.slot_index] = 1'b0;
                end
                OP_CLEAR: begin
                    for (i = 0; i < MAX_DEADLINES; i++)
                        slot_valid[i] = 1'b0;
                end
                default: ;
            endcase

            secs = now / TICKS_PER_SECOND;
            if (secs > last_second) begin
                last_second      = secs;
                r.second_changed = 1'b1;
            end

            // tick arithmetic wraps; ms values are widened then clamped
            since = now - turn_start;
            held  = paused_total + (stopped ? now - stop_began : 32'd0);
            run   = since - held;
            r.elapsed_ms = (held > since) ? 32'd0 : clamp_ms(64'(run) * MS_PER_TICK);

            cur_ms = 64'(now) * MS_PER_TICK;
            for (i = 0; i < MAX_DEADLINES; i++) begin
                if (slot_valid[i]) begin
                    shifted = slot_start[i] + held;
                    end_ms  = 64'(shifted) * MS_PER_TICK + 64'(slot_length[i]);
                    left    = (end_ms < cur_ms) ? 64'd0 : end_ms - cur_ms;
                    if (left == 0)
                        r.any_reached = 1'b1;
                    if (!any || left < min_left)
                        min_left = left;
                    any = 1'b1;
                end
            end
            r.has_deadline     = any;
            r.time_to_first_ms = clamp_ms(min_left);
            expected_reports   = {expected_reports, r};
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                flag(what, want, got);
        endfunction

        function void check_report(t_event_out got);
            t_event_out want;

            if (expected_reports.size() == 0) begin
                flag("unrequested result (elapsed_ms)", '0, got.elapsed_ms);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
            compare_field("time_to_first_ms", want.time_to_first_ms, got.time_to_first_ms);
            compare_field("any_reached", 32'(want.any_reached), 32'(got.any_reached));
            compare_field("has_deadline", 32'(want.has_deadline), 32'(got.has_deadline));
            compare_field("assigned_slot", 32'(want.assigned_slot), 32'(got.assigned_slot));
            compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
            compare_field("second_changed", 32'(want.second_changed),
                          32'(got.second_changed));
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_event_in  i_event = '0;
    logic       busy;
    logic       o_strobe;
    t_event_out o_result;

    clock_deadline_scoreboard board;
    logic [31:0] game_now;
    logic        no_idle;
    int unsigned cycles;
    t_event_in   opening[$];

    pausable_clock_with_deadlines DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_event  (i_event),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // results sampled mid-cycle, clear of the rising-edge updates
    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            board.check_report(o_result);
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic t_event_in make_event(logic [2:0] op, logic [31:0] now,
                                             logic [31:0] from, logic [31:0] len,
                                             logic [2:0] idx);
        t_event_in ev;

        ev.opcode      = op;
        ev.now_ticks   = now;
        ev.from_ticks  = from;
        ev.deadline_ms = len;
        ev.slot_index  = idx;
        return ev;
    endfunction

    function automatic void queue_opening(t_event_in ev);
        opening = {opening, ev};
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;

        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly a forward-running game clock with sensible requests, some noise
    function automatic t_event_in next_random_event();
        t_event_in   ev;
        int unsigned r;
        int unsigned pick;

        r = $urandom_range(99);
        if (r < 80)
            game_now = game_now + $urandom_range(0, 60);
        else if (r < 98)
            game_now = game_now + $urandom_range(61, 2000);
        else
            game_now = game_now + $urandom_range(0, 32'h00FF_FFFF);

        ev.opcode      = OP_TICK;
        ev.now_ticks   = game_now;
        ev.from_ticks  = $urandom;
        ev.deadline_ms = $urandom;
        ev.slot_index  = 3'($urandom_range(7));

        if ($urandom_range(99) < 5) begin
            ev.opcode    = 3'($urandom_range(7));
            ev.now_ticks = game_now - $urandom_range(0, 500);
            return ev;
        end

        pick = $urandom_range(99);
        if (pick < 34) begin
            ev.opcode = OP_TICK;
        end else if (pick < 54) begin
            ev.opcode = OP_ADD;
            if ($urandom_range(1))
                ev.from_ticks = game_now - $urandom_range(0, 50);
            else
                ev.from_ticks = game_now + $urandom_range(0, 50);
            if ($urandom_range(9) != 0)
                ev.deadline_ms = $urandom_range(0, 3000);
        end else if (pick < 68) begin
            ev.opcode = OP_REMOVE;
        end else if (pick < 76) begin
            ev.opcode = OP_STOP;
        end else if (pick < 84) begin
            ev.opcode = OP_RESUME;
        end else if (pick < 90) begin
            ev.opcode     = OP_RESTART;
            ev.from_ticks = game_now - $urandom_range(0, 200);
        end else if (pick < 94) begin
            ev.opcode = OP_CLEAR;
        end else begin
            ev.opcode = OP_SPARE;
        end
        return ev;
    endfunction

    // keeps start high across back-to-back requests
    task automatic issue_event(input t_event_in ev, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_event <= ev;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(ev);
    endtask

    task automatic wait_for_reports();
        start <= 1'b0;
        do @(posedge i_clk); while (board.expected_reports.size() != 0);
    endtask

    initial begin
        t_event_in ev;

        board    = new();
        game_now = '0;
        no_idle  = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_opening(make_event(OP_TICK,    32'd0,   32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_TICK,    32'd150, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7));
        queue_opening(make_event(OP_RESTART, 32'd200, 32'd100,      32'd0,        3'd0));
        queue_opening(make_event(OP_ADD,     32'd200, 32'd200,      32'd0,        3'd0));
        queue_opening(make_event(OP_ADD,     32'd200, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0));
        for (int i = 0; i < 6; i++)
            queue_opening(make_event(OP_ADD, 32'd210, 32'd205, 32'(100 * (i + 1)), 3'd0));
        // table is full now
        queue_opening(make_event(OP_ADD,     32'd220, 32'd220,      32'd50,       3'd0));
        queue_opening(make_event(OP_REMOVE,  32'd230, 32'd0,        32'd0,        3'd3));
        queue_opening(make_event(OP_REMOVE,  32'd240, 32'd0,        32'd0,        3'd3));
        queue_opening(make_event(OP_ADD,     32'd250, 32'd250,      32'd40,       3'd0));
        queue_opening(make_event(OP_STOP,    32'd300, 32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_STOP,    32'd350, 32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_TICK,    32'd400, 32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_RESTART, 32'd450, 32'd420,      32'd0,        3'd0));
        queue_opening(make_event(OP_RESUME,  32'd500, 32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_RESUME,  32'd520, 32'd0,        32'd0,        3'd0));
        // stopped from an earlier tick: paused time exceeds run time
        queue_opening(make_event(OP_STOP,    32'd300, 32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_TICK,    32'd525, 32'd0,        32'd0,        3'd0));
        queue_opening(make_event(OP_SPARE,   32'd530, 32'd0,        32'd0,        3'd0));
        // restart in the future while stopped: tick differences wrap and run time is zero
        queue_opening(make_event(OP_RESTART, 32'd600, 32'd601,      32'd0,        3'd0));
        queue_opening(make_event(OP_CLEAR,   32'd610, 32'd0,        32'd0,        3'd0));

        foreach (opening[i])
            issue_event(opening[i], idle_gap());
        wait_for_reports();

        game_now = 32'd1000;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0)
                no_idle = ($urandom_range(3) == 0);
            ev = next_random_event();
            // late phase: clock runs up to the top of the tick range and wraps
            if (n == RANDOM_REQUESTS - 150) begin
                ev.opcode    = OP_TICK;
                ev.now_ticks = 32'hFFFF_FFFF;
                game_now     = 32'hFFFF_FFFF;
            end
            if (n % 300 == 299)
                wait_for_reports();
            issue_event(ev, idle_gap());
        end

        wait_for_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/pcwd_pkg.sv
design/pcwd_cell.sv
design/pausable_clock_with_deadlines.sv
verif/pausable_clock_with_deadlines_tb.sv
